FILE: rtl/fol_pkg.sv
`timescale 1ns / 1ps

package fol_pkg;

  localparam int ValueW = 32;
  localparam int CountW = 16;
  localparam int PosW   = 4;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  // item kinds
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_LOCATE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BADINDEX = 2'd3;

  typedef struct packed {
    logic [1:0]               status;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] entry_value;
    logic [CountW-1:0]        entry_count;
  } res_t;

endpackage

FILE: rtl/frequency_ordered_list_top.sv
`timescale 1ns / 1ps

// Frequency-ordered table of up to DEPTH signed 32-bit values, each with a
// saturating 16-bit access count, held in one single-port-read /
// single-port-write memory with a registered read. One item is worked
// at a time; the finished result sits in an output register so the next item
// is taken while it waits. A locate walks the memory from the front, one
// entry per cycle, until a hit or the fill count. On a hit it walks back past
// every earlier entry whose count is not above the new count (each step reads
// the next earlier entry while the entry behind it is written one slot down).
// The memory read port sets this pace. No clearing pass is needed after
// reset: only entries below the fill count are ever used.
module frequency_ordered_list_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] value, [35:32] index, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] position, [35:4] entry_value, [51:36] entry_count, [55:52] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int AW   = $clog2(DEPTH);
  localparam int TW   = AW + 1;
  localparam int CMPW = (TW > fol_pkg::PosW) ? TW : fol_pkg::PosW;
  localparam int WW   = fol_pkg::ValueW + fol_pkg::CountW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  function automatic logic [fol_pkg::PosW-1:0] pos4(logic [AW-1:0] p);
    logic [CMPW-1:0] e;
    e = CMPW'(p);
    return e[fol_pkg::PosW-1:0];
  endfunction

  // entry word: {value, count}
  logic [WW-1:0] mem_q [DEPTH];
  logic [WW-1:0] rdata_q;

  logic [2:0]  state_q, state_d;
  logic [TW-1:0] total_q, total_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic signed [fol_pkg::ValueW-1:0] val_q, val_d;
  logic [fol_pkg::CountW-1:0] cnt_q, cnt_d;
  fol_pkg::res_t res_q, res_d;
  fol_pkg::res_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [WW-1:0] mem_wd;
  logic [AW-1:0] rd_addr;

  logic in_fire;
  logic out_free;
  logic [1:0] in_op;
  logic signed [fol_pkg::ValueW-1:0] in_value;
  logic [CMPW-1:0] idx_ext;
  logic signed [fol_pkg::ValueW-1:0] rd_val;
  logic [fol_pkg::CountW-1:0] rd_cnt;
  logic [fol_pkg::CountW-1:0] cnt_inc;
  logic [TW-1:0] next_ptr;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign in_op    = s_axis_tuser;
  assign in_value = s_axis_tdata[31:0];
  assign idx_ext  = CMPW'(s_axis_tdata[35:32]);

  assign rd_val  = rdata_q[WW-1:fol_pkg::CountW];
  assign rd_cnt  = rdata_q[fol_pkg::CountW-1:0];
  assign cnt_inc = (rd_cnt == fol_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
  assign next_ptr = TW'(ptr_q) + 1'b1;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    ptr_d       = ptr_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_wa      = ptr_q;
    mem_wd      = {val_q, cnt_q};
    rd_addr     = ptr_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d   = in_value;
          state_d = S_DONE;
          case (in_op)
            fol_pkg::OP_LOAD: begin
              if (total_q == TW'(DEPTH)) begin
                res_d = '{fol_pkg::ST_FULL, '0, '0, '0};
              end else begin
                mem_we  = 1'b1;
                mem_wa  = total_q[AW-1:0];
                mem_wd  = {in_value, {fol_pkg::CountW{1'b0}}};
                res_d   = '{fol_pkg::ST_OK, pos4(total_q[AW-1:0]), in_value, '0};
                total_d = total_q + 1'b1;
              end
            end
            fol_pkg::OP_LOCATE: begin
              if (total_q == '0) begin
                res_d = '{fol_pkg::ST_NOTFOUND, '0, '0, '0};
              end else begin
                ptr_d   = '0;
                rd_addr = '0;
                state_d = S_SEARCH;
              end
            end
            fol_pkg::OP_READ: begin
              if (idx_ext >= CMPW'(total_q)) begin
                res_d = '{fol_pkg::ST_BADINDEX, '0, '0, '0};
              end else begin
                ptr_d   = idx_ext[AW-1:0];
                rd_addr = idx_ext[AW-1:0];
                state_d = S_RDWAIT;
              end
            end
            default: begin
              res_d = '{fol_pkg::ST_OK, '0, '0, '0};
            end
          endcase
        end
      end

      // data for ptr_q is in rdata_q; issue the next read each cycle
      S_SEARCH: begin
        if (rd_val == val_q) begin
          cnt_d = cnt_inc;
          if (ptr_q == '0) begin
            state_d = S_PLACE;
          end else begin
            rd_addr = ptr_q - 1'b1;
            state_d = S_WALK;
          end
        end else if (next_ptr < total_q) begin
          ptr_d   = next_ptr[AW-1:0];
          rd_addr = next_ptr[AW-1:0];
        end else begin
          res_d   = '{fol_pkg::ST_NOTFOUND, '0, '0, '0};
          state_d = S_DONE;
        end
      end

      // rdata_q holds entry ptr_q-1; shift it down or settle at ptr_q
      S_WALK: begin
        mem_we = 1'b1;
        mem_wa = ptr_q;
        if (rd_cnt <= cnt_q) begin
          mem_wd = rdata_q;
          ptr_d  = ptr_q - 1'b1;
          if (ptr_q == AW'(1)) begin
            state_d = S_PLACE;
          end else begin
            rd_addr = ptr_q - AW'(2);
          end
        end else begin
          res_d   = '{fol_pkg::ST_OK, pos4(ptr_q), val_q, cnt_q};
          state_d = S_DONE;
        end
      end

      S_PLACE: begin
        mem_we  = 1'b1;
        res_d   = '{fol_pkg::ST_OK, pos4(ptr_q), val_q, cnt_q};
        state_d = S_DONE;
      end

      S_RDWAIT: begin
        res_d   = '{fol_pkg::ST_OK, pos4(ptr_q), rd_val, rd_cnt};
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // table memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    val_q <= val_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {4'b0000, out_q.entry_count, out_q.entry_value, out_q.position};

endmodule

FILE: tb/sv/frequency_ordered_list_top_tb.sv
`timescale 1ns / 1ps

module frequency_ordered_list_top_tb;

  localparam int ENTRIES        = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * ENTRIES + 8;
  localparam int CLIMB_LIMIT    = 120;

  // the fourth item kind has no package name; the block answers it with zeros
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {SINK_READY, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // [31:0] value, [35:32] index, [39:36] zero
  logic [1:0]  s_axis_tuser  = '0;  // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // [3:0] position, [35:4] entry_value,
                                    // [51:36] entry_count, [55:52] zero
  logic [1:0]  m_axis_tuser;        // [1:0] status

  // shadow copy of the table, updated as each item is taken
  logic [31:0] tbl_value [ENTRIES];
  logic [15:0] tbl_count [ENTRIES];
  int          tbl_fill = 0;

  fol_pkg::res_t pending_results [$];
  int          error_count = 0;
  int          idle_cycles = 0;

  // sender burst shaping
  int          burst_left    = 0;
  bit          sender_idles  = 1'b0;

  // receiver stall shaping
  sink_mode_e  sink_mode     = SINK_READY;
  logic [15:0] stall_pattern = '1;
  logic [3:0]  stall_phase   = '0;
  bit          hold_req      = 1'b0;
  int          hold_left     = 0;

  frequency_ordered_list_top #(
    .DEPTH(ENTRIES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the result of one item and advance the shadow table.
  function automatic fol_pkg::res_t predict_result(input logic [1:0] op,
                                                   input logic [31:0] val,
                                                   input logic [3:0] idx);
    fol_pkg::res_t r;
    int          hit;
    int          dst;
    logic [15:0] cnt;
    r = '0;
    case (op)
      fol_pkg::OP_LOAD: begin
        if (tbl_fill >= ENTRIES) begin
          r.status = fol_pkg::ST_FULL;
        end else begin
          tbl_value[tbl_fill] = val;
          tbl_count[tbl_fill] = '0;
          r.status      = fol_pkg::ST_OK;
          r.position    = 4'(tbl_fill);
          r.entry_value = val;
          tbl_fill++;
        end
      end
      fol_pkg::OP_LOCATE: begin
        hit = 0;
        while (hit < tbl_fill && tbl_value[hit] != val) hit++;
        if (hit >= tbl_fill) begin
          r.status = fol_pkg::ST_NOTFOUND;
        end else begin
          cnt = tbl_count[hit];
          if (cnt != fol_pkg::COUNT_MAX) cnt++;
          // slide forward past every earlier entry whose count is not greater
          dst = hit;
          while (dst > 0 && tbl_count[dst-1] <= cnt) dst--;
          for (int k = hit; k > dst; k--) begin
            tbl_value[k] = tbl_value[k-1];
            tbl_count[k] = tbl_count[k-1];
          end
          tbl_value[dst] = val;
          tbl_count[dst] = cnt;
          r.status      = fol_pkg::ST_OK;
          r.position    = 4'(dst);
          r.entry_value = val;
          r.entry_count = cnt;
        end
      end
      fol_pkg::OP_READ: begin
        if (int'(idx) >= tbl_fill) begin
          r.status = fol_pkg::ST_BADINDEX;
        end else begin
          r.status      = fol_pkg::ST_OK;
          r.position    = idx;
          r.entry_value = tbl_value[idx];
          r.entry_count = tbl_count[idx];
        end
      end
      default: ;  // unused kind: all-zero result, table untouched
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one item and hold it until taken. Call at a rising edge; returns at
  // the rising edge where the item was accepted.
  task automatic send_item(input logic [1:0] op, input logic [31:0] val,
                           input logic [3:0] idx);
    int   gap;
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, idx, val};
    s_axis_tuser  <= op;
    // sample the handshake mid-cycle, where nothing is changing
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    pending_results.push_back(predict_result(op, val, idx));
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Empty table: read out of range, miss, and the unused kind.
  task automatic test_empty_table();
    sink_mode    = SINK_READY;
    sender_idles = 1'b0;
    send_item(fol_pkg::OP_READ, 32'h0, 4'd0);
    send_item(fol_pkg::OP_READ, 32'hFFFF_FFFF, 4'd15);
    send_item(fol_pkg::OP_LOCATE, 32'h0, 4'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
    wait_drain();
  endtask

  // Extreme values, a hit on the last entry, equal-count moves, reads.
  task automatic test_load_extremes();
    sink_mode = SINK_RANDOM;
    send_item(fol_pkg::OP_LOAD, 32'h8000_0000, 4'd0);
    send_item(fol_pkg::OP_LOAD, 32'h7FFF_FFFF, 4'd15);
    send_item(fol_pkg::OP_LOAD, 32'h0000_0000, 4'd0);
    send_item(fol_pkg::OP_LOAD, 32'hFFFF_FFFF, 4'd0);
    send_item(fol_pkg::OP_LOCATE, 32'hFFFF_FFFF, 4'd0);  // last entry, moves to the front
    send_item(fol_pkg::OP_LOCATE, 32'h8000_0000, 4'd0);  // passes an equal count
    send_item(fol_pkg::OP_LOCATE, 32'h1234_5678, 4'd0);  // miss
    send_item(fol_pkg::OP_READ, 32'h0, 4'd0);
    send_item(fol_pkg::OP_READ, 32'h0, 4'd3);
    send_item(fol_pkg::OP_READ, 32'h0, 4'd4);            // one past the fill
    wait_drain();
  endtask

  // Stall the output long enough that the block backs up into its input.
  task automatic test_backpressure();
    sink_mode    = SINK_READY;
    sender_idles = 1'b0;
    hold_req     = 1'b1;
    send_item(fol_pkg::OP_LOCATE, 32'h7FFF_FFFF, 4'd0);
    send_item(fol_pkg::OP_READ, 32'h0, 4'd1);
    send_item(fol_pkg::OP_LOCATE, 32'h0, 4'd0);
    send_item(fol_pkg::OP_READ, 32'h0, 4'd2);
    send_item(fol_pkg::OP_LOAD, $urandom, 4'd0);
    send_item(fol_pkg::OP_LOCATE, 32'h7FFF_FFFF, 4'd0);
    send_item(fol_pkg::OP_READ, 32'h0, 4'd0);
    send_item(OP_UNUSED, 32'h0, 4'd0);
    wait_drain();
  endtask

  // Mostly hits on stored values so counts build up and entries move.
  task automatic test_random_traffic(input int n_items);
    int          pick;
    int          slot;
    logic [31:0] val;
    for (int i = 0; i < n_items; i++) begin
      // reshape idling every 50 items, and sometimes wait for the tail
      if (i % 50 == 0) begin
        sink_mode    = sink_mode_e'($urandom_range(0, 2));
        sender_idles = $urandom_range(0, 2) != 0;
        if ($urandom_range(0, 2) == 0) wait_drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        case ($urandom_range(0, 7))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h0000_0000;
          3:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        send_item(fol_pkg::OP_LOAD, val, 4'($urandom));
      end else if (pick < 60 && tbl_fill > 0) begin
        // bias toward later entries now and then so deep entries climb
        slot = $urandom_range(0, tbl_fill - 1);
        if ($urandom_range(0, 3) == 0) slot = $urandom_range(slot, tbl_fill - 1);
        send_item(fol_pkg::OP_LOCATE, tbl_value[slot], 4'($urandom));
      end else if (pick < 70) begin
        send_item(fol_pkg::OP_LOCATE, $urandom, 4'($urandom));
      end else if (pick < 95) begin
        send_item(fol_pkg::OP_READ, $urandom, 4'($urandom));
      end else begin
        send_item(OP_UNUSED, $urandom, 4'($urandom));
      end
    end
    wait_drain();
  endtask

  // Fill to the top, then load into a full table and read the last slot.
  task automatic test_full_table();
    sink_mode    = SINK_PATTERN;
    sender_idles = 1'b1;
    while (tbl_fill < ENTRIES) send_item(fol_pkg::OP_LOAD, $urandom, 4'd0);
    send_item(fol_pkg::OP_LOAD, 32'h8000_0000, 4'd0);
    send_item(fol_pkg::OP_LOAD, 32'h7FFF_FFFF, 4'd15);
    send_item(fol_pkg::OP_READ, 32'h0, 4'd15);
    wait_drain();
  endtask

  // Hit the front entry, then raise a later entry until it passes the front
  // one on an equal count; then hit the old front entry again.
  task automatic test_equal_counts();
    logic [31:0] front_val;
    logic [31:0] other_val;
    int          slot;
    int          tries;
    bit          unique_found;
    sink_mode    = SINK_READY;
    sender_idles = 1'b0;
    front_val = tbl_value[0];
    other_val = '0;
    send_item(fol_pkg::OP_LOCATE, front_val, 4'd0);  // stays at the front
    // pick an entry whose value is its own first occurrence
    unique_found = 1'b0;
    for (slot = 1; slot < tbl_fill && !unique_found; slot++) begin
      unique_found = 1'b1;
      for (int k = 0; k < slot; k++) begin
        if (tbl_value[k] == tbl_value[slot]) unique_found = 1'b0;
      end
      if (unique_found) other_val = tbl_value[slot];
    end
    if (unique_found) begin
      tries = 0;
      while (tbl_value[0] != other_val && tries < CLIMB_LIMIT) begin
        send_item(fol_pkg::OP_LOCATE, other_val, 4'd0);
        tries++;
      end
      send_item(fol_pkg::OP_LOCATE, front_val, 4'd0);
      send_item(fol_pkg::OP_READ, 32'h0, 4'd0);
      send_item(fol_pkg::OP_READ, 32'h0, 4'd1);
    end
    wait_drain();
  endtask

  // Receiver: a long hold-off on request, else the current stall style.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    stall_phase <= stall_phase + 4'd1;
    if (stall_phase == 4'd0) stall_pattern <= $urandom;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_RANDOM:  m_axis_tready <= $urandom_range(0, 3) != 0;
        SINK_PATTERN: m_axis_tready <= stall_pattern[stall_phase];
        default:      m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Check each taken result against the oldest expectation. Sample at the
  // falling edge: the values here are the ones the next rising edge takes.
  always @(negedge clk_i) begin
    fol_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[35:4], 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
        if (m_axis_tdata[3:0] !== want.position)
          report_mismatch("position", 32'(m_axis_tdata[3:0]), 32'(want.position));
        if (m_axis_tdata[35:4] !== want.entry_value)
          report_mismatch("entry_value", m_axis_tdata[35:4], want.entry_value);
        if (m_axis_tdata[51:36] !== want.entry_count)
          report_mismatch("entry_count", 32'(m_axis_tdata[51:36]), 32'(want.entry_count));
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(negedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_load_extremes();
    test_backpressure();
    test_random_traffic(430);
    test_full_table();
    test_equal_counts();
    // hold a while longer to catch any stray result
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: frequency_ordered_list_top.f
rtl/fol_pkg.sv
rtl/frequency_ordered_list_top.sv
tb/sv/frequency_ordered_list_top_tb.sv
